### sv/lkec_pkg.sv
// Shared types and constants for the keyed LRU cache directory.
// No dependencies; imported by the scan unit, the top level and the checker.
package lkec_pkg;

    localparam int KEY_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 5;
    localparam int SLOT_OUT_W = 4;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 104;
    localparam int RAM_W      = KEY_W + STAMP_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctrl_t;

    // what the scan found
    typedef struct packed {
        logic found;
        logic got_free;
        logic any_old;
    } scan_flags_t;

endpackage

### sv/lru_keyed_entry_cache_top.sv
// The result beat is registered in the decide state, after the scan and drain states.
// One request is handled at a time; the scan
// reads one entry per cycle through the single read port of the key/stamp RAM,
// and the next input beat waits until the result beat has been taken.
// Reset (aresetn low, synchronous) clears all valid bits, use count, request
// stamp, hit and miss counters, and sets max_entries to 16. No clearing pass.
// Depends on lkec_pkg, lkec_ram, lkec_scan.
module lru_keyed_entry_cache_top #(
    parameter int SLOTS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lkec_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] request_key
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] hit, [4:1] slot, [5] evicted, [37:6] evicted_key,
    // [69:38] hit_total, [101:70] miss_total, [103:102] zero
    output logic [lkec_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lkec_pkg::CFG_W-1:0]      cfg_data   // max_entries
);
    import lkec_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int USED_W = $clog2(SLOTS + 1);
    localparam int CMP_W  = (USED_W > CFG_W) ? USED_W : CFG_W;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    max_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [CNT_W-1:0]    hit_cnt_reg, miss_cnt_reg, hit_cnt_next, miss_cnt_next;
    logic [USED_W-1:0]   used_reg;
    logic [SLOTS-1:0]    valid_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic                sample_reg;
    logic [IDX_W-1:0]    sample_idx_reg;
    logic                out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    scan_ctrl_t          ctrl;
    scan_flags_t         flags;
    logic [IDX_W-1:0]    hit_slot, free_slot, old_slot;
    logic [KEY_W-1:0]    old_key;
    logic [RAM_W-1:0]    rd_word;

    logic                s_beat, m_beat;
    logic [CMP_W-1:0]    limit;
    logic                fill_ok;
    logic [IDX_W-1:0]    dec_slot;
    logic                dec_evict, set_valid, inc_used;
    logic [KEY_W-1:0]    dec_ev_key;

    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign s_beat    = s_tvalid && s_tready;
    assign m_beat    = out_valid_reg && m_tready;
    assign cfg_ready = 1'b1;

    // effective limit: max_entries clamped to 1..SLOTS
    always_comb begin
        if (max_reg == '0) begin
            limit = CMP_W'(1);
        end else if (CMP_W'(max_reg) > CMP_W'(SLOTS)) begin
            limit = CMP_W'(SLOTS);
        end else begin
            limit = CMP_W'(max_reg);
        end
    end
    assign fill_ok = CMP_W'(used_reg) < limit;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_beat) state_next = ST_SCAN;
            ST_SCAN:   if (addr_reg == IDX_W'(SLOTS - 1)) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // decision on the scan outcome
    always_comb begin
        dec_slot   = '0;
        dec_evict  = 1'b0;
        dec_ev_key = '0;
        set_valid  = 1'b0;
        inc_used   = 1'b0;
        if (flags.found) begin
            dec_slot = hit_slot;
        end else if (fill_ok) begin
            if (flags.got_free) begin
                dec_slot  = free_slot;
                set_valid = 1'b1;
                inc_used  = 1'b1;
            end
        end else begin
            dec_slot = old_slot;
            if (flags.any_old) begin
                dec_evict  = 1'b1;
                dec_ev_key = old_key;
            end else begin
                set_valid = 1'b1;
            end
        end
    end

    assign hit_cnt_next  = hit_cnt_reg + CNT_W'(flags.found);
    assign miss_cnt_next = miss_cnt_reg + CNT_W'(!flags.found);

    assign ctrl.clear  = s_beat;
    assign ctrl.sample = sample_reg;

    lkec_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (state_reg == ST_DECIDE),
        .waddr (dec_slot),
        .wdata ({stamp_reg, key_reg}),
        .raddr (addr_reg),
        .rdata (rd_word)
    );

    lkec_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .idx       (sample_idx_reg),
        .ent_valid (valid_reg[sample_idx_reg]),
        .req_key   (key_reg),
        .now       (stamp_reg),
        .rd_key    (rd_word[KEY_W-1:0]),
        .rd_stamp  (rd_word[RAM_W-1:KEY_W]),
        .flags     (flags),
        .hit_slot  (hit_slot),
        .free_slot (free_slot),
        .old_slot  (old_slot),
        .old_key   (old_key)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            max_reg        <= CFG_RESET;
            stamp_reg      <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            used_reg       <= '0;
            valid_reg      <= '0;
            addr_reg       <= '0;
            sample_reg     <= 1'b0;
            sample_idx_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sample_reg     <= (state_reg == ST_SCAN);
            sample_idx_reg <= addr_reg;
            if (cfg_valid && cfg_ready) begin
                max_reg <= cfg_data;
            end
            if (s_beat) begin
                addr_reg <= '0;
            end else if (state_reg == ST_SCAN) begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
            if (state_reg == ST_DECIDE) begin
                stamp_reg    <= stamp_reg + STAMP_W'(1);
                hit_cnt_reg  <= hit_cnt_next;
                miss_cnt_reg <= miss_cnt_next;
                if (set_valid) valid_reg[dec_slot] <= 1'b1;
                if (inc_used)  used_reg <= used_reg + USED_W'(1);
                out_valid_reg <= 1'b1;
            end else if (m_beat) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            key_reg <= s_tdata[KEY_W-1:0];
        end
        if (state_reg == ST_DECIDE) begin
            out_data_reg <= {2'b00, miss_cnt_next, hit_cnt_next, dec_ev_key, dec_evict,
                             SLOT_OUT_W'(dec_slot), flags.found};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### sv/lkec_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkec_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/lkec_scan.sv
// Per-entry compare and age unit, reused once per slot over the scan.
// Tracks first key match, first free slot and oldest valid entry. Uses lkec_pkg.
module lkec_scan #(
    parameter int SLOTS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lkec_pkg::scan_ctrl_t        ctrl,
    input  logic [$clog2(SLOTS)-1:0]    idx,
    input  logic                        ent_valid,
    input  logic [lkec_pkg::KEY_W-1:0]  req_key,
    input  logic [lkec_pkg::STAMP_W-1:0] now,
    input  logic [lkec_pkg::KEY_W-1:0]  rd_key,
    input  logic [lkec_pkg::STAMP_W-1:0] rd_stamp,
    output lkec_pkg::scan_flags_t       flags,
    output logic [$clog2(SLOTS)-1:0]    hit_slot,
    output logic [$clog2(SLOTS)-1:0]    free_slot,
    output logic [$clog2(SLOTS)-1:0]    old_slot,
    output logic [lkec_pkg::KEY_W-1:0]  old_key
);
    import lkec_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    scan_flags_t        flags_reg, flags_next;
    logic [IDX_W-1:0]   hit_slot_reg, free_slot_reg, old_slot_reg;
    logic [KEY_W-1:0]   old_key_reg;
    logic [STAMP_W-1:0] best_age_reg;
    logic [STAMP_W-1:0] age;
    logic               take_hit, take_free, take_old;

    // wrapping age: larger means older
    assign age       = now - rd_stamp;
    assign take_hit  = ctrl.sample && ent_valid && (rd_key == req_key) && !flags_reg.found;
    assign take_free = ctrl.sample && !ent_valid && !flags_reg.got_free;
    assign take_old  = ctrl.sample && ent_valid && (!flags_reg.any_old || (age > best_age_reg));

    always_comb begin
        flags_next = flags_reg;
        if (ctrl.clear) begin
            flags_next = '0;
        end else begin
            if (take_hit)  flags_next.found    = 1'b1;
            if (take_free) flags_next.got_free = 1'b1;
            if (take_old)  flags_next.any_old  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg     <= '0;
            hit_slot_reg  <= '0;
            free_slot_reg <= '0;
            old_slot_reg  <= '0;
        end else begin
            flags_reg <= flags_next;
            if (ctrl.clear) begin
                hit_slot_reg  <= '0;
                free_slot_reg <= '0;
                old_slot_reg  <= '0;
            end else begin
                if (take_hit)  hit_slot_reg  <= idx;
                if (take_free) free_slot_reg <= idx;
                if (take_old)  old_slot_reg  <= idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_old) begin
            best_age_reg <= age;
            old_key_reg  <= rd_key;
        end
    end

    assign flags     = flags_reg;
    assign hit_slot  = hit_slot_reg;
    assign free_slot = free_slot_reg;
    assign old_slot  = old_slot_reg;
    assign old_key   = old_key_reg;

endmodule

### sv/lkec_checker.sv
// Port-level checker for the keyed LRU cache directory, bound to the top level.
// Depends on lkec_pkg and lru_keyed_entry_cache_top.
module lkec_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lkec_pkg::M_TDATA_W-1:0] m_tdata
);
    import lkec_pkg::*;

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("input taken or result shown right after accept");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    // a hit never evicts, and without an eviction the evicted key is zero
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[0] || !m_tdata[5]) |-> !m_tdata[5] || !m_tdata[0])
        else $error("hit flagged together with an eviction");

    a_evict_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[5] |-> m_tdata[37:6] == '0)
        else $error("evicted key nonzero without an eviction");

endmodule

bind lru_keyed_entry_cache_top lkec_checker u_lkec_checker (.*);

### tb/sv/lkec_directory_checker.sv
// Scoreboard for the keyed LRU cache directory: mirrors the directory state,
// predicts one lookup result per request beat and checks every result beat.
// Depends on lkec_pkg for widths.
module lkec_directory_checker #(
    parameter int SLOTS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lkec_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lkec_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lkec_pkg::CFG_W-1:0]      cfg_data,
    output int                              mismatch_count,
    output int                              pending_count
);
    import lkec_pkg::*;

    // matches the m_tdata layout, msb first
    typedef struct packed {
        logic [1:0]       pad;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] hit_total;
        logic [KEY_W-1:0] evicted_key;
        logic             evicted;
        logic [3:0]       slot;
        logic             hit;
    } lookup_t;

    logic               ent_valid [SLOTS];
    logic [KEY_W-1:0]   ent_key   [SLOTS];
    logic [STAMP_W-1:0] ent_stamp [SLOTS];
    int                 used_cnt;
    logic [STAMP_W-1:0] req_stamp;
    logic [CNT_W-1:0]   hit_cnt;
    logic [CNT_W-1:0]   miss_cnt;
    logic [CFG_W-1:0]   limit_reg;

    lookup_t expected_lookups [$];
    int      errs = 0;

    task automatic clear_directory();
        for (int i = 0; i < SLOTS; i++) begin
            ent_valid[i] = 1'b0;
            ent_key[i]   = '0;
            ent_stamp[i] = '0;
        end
        used_cnt  = 0;
        req_stamp = '0;
        hit_cnt   = '0;
        miss_cnt  = '0;
        limit_reg = CFG_RESET;
    endtask

    function automatic lookup_t predict_lookup(input logic [KEY_W-1:0] key);
        lookup_t            r;
        logic [STAMP_W-1:0] now;
        logic [STAMP_W-1:0] age;
        logic [STAMP_W-1:0] best_age;
        int                 lim;
        int                 idx;
        logic               found;
        logic               got_free;
        logic               any_valid;
        r     = '0;
        now   = req_stamp;
        idx   = 0;
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!found && ent_valid[i] && ent_key[i] == key) begin
                found = 1'b1;
                idx   = i;
            end
        end
        if (found) begin
            r.hit          = 1'b1;
            hit_cnt        = hit_cnt + 1'b1;
            ent_stamp[idx] = now;
        end else begin
            miss_cnt = miss_cnt + 1'b1;
            lim = int'(limit_reg);
            if (lim < 1) lim = 1;
            if (lim > SLOTS) lim = SLOTS;
            if (used_cnt < lim) begin
                got_free = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!got_free && !ent_valid[i]) begin
                        got_free = 1'b1;
                        idx      = i;
                    end
                end
                if (got_free) begin
                    ent_valid[idx] = 1'b1;
                    used_cnt++;
                end
            end else begin
                // oldest by wrapping age, first index wins ties
                any_valid = 1'b0;
                best_age  = '0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (ent_valid[i]) begin
                        age = now - ent_stamp[i];
                        if (!any_valid || age > best_age) begin
                            best_age  = age;
                            idx       = i;
                            any_valid = 1'b1;
                        end
                    end
                end
                if (any_valid) begin
                    r.evicted     = 1'b1;
                    r.evicted_key = ent_key[idx];
                end else begin
                    ent_valid[idx] = 1'b1;
                end
            end
            ent_key[idx]   = key;
            ent_stamp[idx] = now;
        end
        req_stamp    = now + 1'b1;
        r.slot       = 4'(idx);
        r.hit_total  = hit_cnt;
        r.miss_total = miss_cnt;
        return r;
    endfunction

    always @(posedge aclk) begin
        lookup_t got;
        lookup_t want;
        if (!aresetn) begin
            clear_directory();
            expected_lookups.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_data;
            if (s_tvalid && s_tready)
                expected_lookups.push_back(predict_lookup(s_tdata[KEY_W-1:0]));
            if (m_tvalid && m_tready) begin
                got = lookup_t'(m_tdata);
                if (expected_lookups.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("result beat with no request pending: %h", m_tdata);
                end else begin
                    want = expected_lookups.pop_front();
                    if (got.hit !== want.hit || got.slot !== want.slot ||
                        got.evicted !== want.evicted ||
                        got.evicted_key !== want.evicted_key ||
                        got.hit_total !== want.hit_total ||
                        got.miss_total !== want.miss_total ||
                        got.pad !== want.pad) begin
                        errs++;
                        if (errs <= 10) begin
                            $display("lookup mismatch exp: hit=%0d slot=%0d ev=%0d ev_key=%h",
                                     want.hit, want.slot, want.evicted, want.evicted_key,
                                     " hits=%0d misses=%0d pad=%0d",
                                     want.hit_total, want.miss_total, want.pad);
                            $display("                got: hit=%0d slot=%0d ev=%0d ev_key=%h",
                                     got.hit, got.slot, got.evicted, got.evicted_key,
                                     " hits=%0d misses=%0d pad=%0d",
                                     got.hit_total, got.miss_total, got.pad);
                        end
                    end
                end
            end
        end
        pending_count  <= expected_lookups.size();
        mismatch_count <= errs;
    end

endmodule

### tb/sv/tb_lru_keyed_entry_cache_top.sv
// Top of the cache directory testbench: clock, reset, request and limit stimulus,
// result back-pressure and the final verdict.
// Depends on lkec_pkg, lru_keyed_entry_cache_top and lkec_directory_checker.
module tb_lru_keyed_entry_cache_top;
    import lkec_pkg::*;

    localparam int SLOTS      = 16;
    localparam int LONG_HOLD  = 250;
    localparam int PHASE_REQS = 92;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [31:0] request_key
    logic                  m_tvalid;
    logic                  m_tready;
    // [0] hit, [4:1] slot, [5] evicted, [37:6] evicted_key,
    // [69:38] hit_total, [101:70] miss_total, [103:102] zero
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;  // max_entries

    int mismatch_count;
    int pending_count;

    int gap_pct     = 0;
    int rx_idle_pct = 0;
    bit quiet       = 1'b0;
    int reqs_sent   = 0;
    bit hold_done   = 1'b0;

    lru_keyed_entry_cache_top #(.SLOTS(SLOTS)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    lkec_directory_checker #(.SLOTS(SLOTS)) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side back-pressure, with one long hold-off to fill the block
    initial begin : result_sink
        m_tready <= 1'b0;
        forever begin
            if (!hold_done && !quiet && reqs_sent >= 200) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && rx_idle_pct != 0 &&
                         $urandom_range(0, 99) < rx_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic reroll_idling();
        if (quiet) begin
            gap_pct     = 0;
            rx_idle_pct = 0;
        end else begin
            gap_pct     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
            rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
        end
    endtask

    task automatic send_key(input logic [KEY_W-1:0] key);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        reqs_sent++;
    endtask

    // waits for the directory to drain, then writes the limit
    task automatic write_limit(input logic [CFG_W-1:0] limit_val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit_val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // mostly keys from a small pool so hits and evictions are frequent
    task automatic run_phase(input logic [CFG_W-1:0] limit_val, input int n_reqs);
        logic [KEY_W-1:0] key_pool [$];
        int               pool_size;
        write_limit(limit_val);
        pool_size = $urandom_range(2, 24);
        for (int i = 0; i < pool_size; i++)
            key_pool.push_back($urandom);
        for (int n = 0; n < n_reqs; n++) begin
            if (n % 32 == 0)
                reroll_idling();
            if ($urandom_range(0, 99) < 85)
                send_key(key_pool[$urandom_range(0, pool_size - 1)]);
            else
                send_key($urandom);
        end
    endtask

    initial begin : stimulus
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_pct     = 20;
        rx_idle_pct = 20;

        // zero limit acts as one slot: second key evicts key zero
        write_limit(5'd0);
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'hFFFF_FFFF);

        // free slot fills, then replacement of the oldest entry
        write_limit(5'd3);
        send_key(32'h0000_0000);
        send_key(32'h0000_0005);
        send_key(32'h0000_0006);
        send_key(32'h0000_0000);

        // out-of-range limit clamps to the full table
        write_limit(5'd31);
        for (int i = 0; i < 13; i++)
            send_key(32'h0000_0100 + i);
        send_key(32'h0000_0100);
        send_key(32'h0000_ABCD);

        // random part; limit lowered below use in the third to sixth phases
        run_phase(5'd17, PHASE_REQS);
        run_phase(5'd16, PHASE_REQS);
        run_phase(5'd2,  PHASE_REQS);
        run_phase(5'd1,  PHASE_REQS);
        run_phase(5'd0,  PHASE_REQS);
        run_phase(5'd8,  PHASE_REQS);
        run_phase(CFG_W'($urandom_range(0, 31)), PHASE_REQS);
        run_phase(5'd31, PHASE_REQS);
        quiet = 1'b1;
        run_phase(5'd16, PHASE_REQS);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SLOTS + 8) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
